// ===== src/qer_pkg.sv =====
// shared constants and types for the quadratic evaluator and root solver
`timescale 1ns / 1ps
package qer_pkg;

  localparam int COEF_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF  = 8;
  localparam int WORD_W         = 64;
  localparam int POLY_W         = 39;
  localparam int OUT_FRAC       = 16;
  localparam int ROOT_EXTRA     = 15;
  localparam int ROOT_W         = 32;
  localparam int SQRT_STEPS     = 32;
  localparam int DIV_STEPS      = 32;
  localparam int REG_IDX_W      = 2;

  localparam logic [REG_IDX_W-1:0] REG_LEAD   = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_LINEAR = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_CONST  = 2'd2;

  localparam logic [1:0] KIND_NONE   = 2'd0;
  localparam logic [1:0] KIND_DOUBLE = 2'd1;
  localparam logic [1:0] KIND_TWO    = 2'd2;
  localparam logic [1:0] KIND_LINEAR = 2'd3;

  // running state of the digit-by-digit square root
  typedef struct packed {
    logic [WORD_W-1:0] rem;
    logic [WORD_W-1:0] res;
  } sqrt_lane_t;

  // partial remainder and quotient of one division lane
  typedef struct packed {
    logic [WORD_W-1:0] rem;
    logic [ROOT_W-1:0] quo;
  } div_lane_t;

  typedef struct packed {
    div_lane_t plus;
    div_lane_t minus;
  } div_pair_t;

endpackage

// ===== src/qer_sqrt_cell.sv =====
// one step of the pipelined integer square root
`timescale 1ns / 1ps
module qer_sqrt_cell #(
  parameter int STEP = 0
) (
  input  logic                clk,
  input  logic                en,
  input  qer_pkg::sqrt_lane_t din,
  output qer_pkg::sqrt_lane_t dout
);

  localparam logic [qer_pkg::WORD_W-1:0] BIT_VAL =
    qer_pkg::WORD_W'(1) << (qer_pkg::WORD_W - 2 - 2 * STEP);

  logic [qer_pkg::WORD_W-1:0] trial;
  qer_pkg::sqrt_lane_t        step_next;

  assign trial = din.res + BIT_VAL;

  always_comb begin
    if (din.rem >= trial) begin
      step_next.rem = din.rem - trial;
      step_next.res = (din.res >> 1) + BIT_VAL;
    end else begin
      step_next.rem = din.rem;
      step_next.res = din.res >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= step_next;
    end
  end

endmodule

// ===== src/qer_div_cell.sv =====
// one quotient bit for both root divisions
`timescale 1ns / 1ps
module qer_div_cell #(
  parameter int SHIFT = 0
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic [qer_pkg::WORD_W-1:0] divisor,
  input  qer_pkg::div_pair_t         din,
  output qer_pkg::div_pair_t         dout
);

  logic [qer_pkg::WORD_W-1:0] dshift;
  qer_pkg::div_pair_t         step_next;

  // divisor never exceeds 2^32, so the shift stays inside the word
  assign dshift = divisor << SHIFT;

  always_comb begin
    step_next = din;
    if (din.plus.rem >= dshift) begin
      step_next.plus.rem        = din.plus.rem - dshift;
      step_next.plus.quo[SHIFT] = 1'b1;
    end
    if (din.minus.rem >= dshift) begin
      step_next.minus.rem        = din.minus.rem - dshift;
      step_next.minus.quo[SHIFT] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= step_next;
    end
  end

endmodule

// ===== src/quadratic_eval_and_roots.sv =====
// top level: quadratic evaluation and real roots, fully pipelined
`timescale 1ns / 1ps
// The user must load the coefficients lead_coef, linear_coef and const_coef
// through the write port (cfg_we, cfg_index, cfg_data) only while no request
// is in flight; the block does not enforce it. Each request on the in
// channel carries one eval_point and yields exactly one result on the out
// channel with poly_value, root_kind, both roots and the saturation flag.
// From acceptance to out_valid a request passes two multiply stages,
// 32 square-root cells, one set-up stage for the divisions, 32 divide cells
// (one quotient bit each for both roots) and the output register.
// Throughput is one request per cycle when not stalled, set by the chains.
// When the receiver holds out_ready low with a result waiting, the whole
// pipeline holds, bubbles included, and in_ready falls.
// Reset clears the coefficients to zero and empties the pipeline.
module quadratic_eval_and_roots #(
  parameter int COEF_WIDTH = qer_pkg::COEF_WIDTH_DEF,
  parameter int FRAC_BITS  = qer_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [qer_pkg::REG_IDX_W-1:0]       cfg_index,
  input  logic [COEF_WIDTH-1:0]               cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [COEF_WIDTH-1:0]        eval_point,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [qer_pkg::POLY_W-1:0]   poly_value,
  output logic [1:0]                          root_kind,
  output logic signed [qer_pkg::ROOT_W-1:0]   root_plus,
  output logic signed [qer_pkg::ROOT_W-1:0]   root_minus,
  output logic                                root_saturated
);

  localparam int W     = qer_pkg::WORD_W;
  localparam int NS    = qer_pkg::SQRT_STEPS;
  localparam int ND    = qer_pkg::DIV_STEPS;
  localparam int SH    = 3 * FRAC_BITS - qer_pkg::OUT_FRAC;
  localparam int SH_R  = (SH > 0) ? SH : 0;
  localparam int SH_L  = (SH < 0) ? -SH : 0;
  localparam int NVLD  = NS + ND + 3;
  localparam int NSIDE = NS + ND + 1;

  typedef struct packed {
    logic [qer_pkg::POLY_W-1:0] poly;
    logic [1:0]                 kind;
  } side_t;

  typedef struct packed {
    logic neg_p;
    logic big_p;
    logic neg_m;
    logic big_m;
  } flag_t;

  logic signed [COEF_WIDTH-1:0] lead_coef;
  logic signed [COEF_WIDTH-1:0] linear_coef;
  logic signed [COEF_WIDTH-1:0] const_coef;

  logic en;
  logic [NVLD-1:0] vld;

  logic signed [2*COEF_WIDTH-1:0] xx, xb, bb, ac;
  logic signed [3*COEF_WIDTH-1:0] xxa;
  logic signed [W-1:0] poly_full, poly_scaled, disc;
  logic [1:0] kind_s1;
  logic [qer_pkg::POLY_W-1:0] poly_s1;

  logic signed [W-1:0] a64, b64, c64, poly_next, disc_next;
  logic [W-1:0] md, base;

  qer_pkg::sqrt_lane_t sq_in;
  qer_pkg::sqrt_lane_t sq [NS];
  qer_pkg::div_pair_t  dv_in;
  qer_pkg::div_pair_t  dv [ND];
  side_t side [NSIDE];
  flag_t flg [ND+1];

  logic [W-1:0] np, nm, mnp, mnm;
  logic         nnp, nnm;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  assign a64  = W'(lead_coef);
  assign b64  = W'(linear_coef);
  assign c64  = W'(const_coef);
  assign md   = lead_coef[COEF_WIDTH-1] ? W'(-a64) : W'(a64);
  assign base = W'(-b64) << qer_pkg::ROOT_EXTRA;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      lead_coef   <= '0;
      linear_coef <= '0;
      const_coef  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        qer_pkg::REG_LEAD:   lead_coef   <= cfg_data;
        qer_pkg::REG_LINEAR: linear_coef <= cfg_data;
        qer_pkg::REG_CONST:  const_coef  <= cfg_data;
        default: ;
      endcase
    end
  end

  // valid line through all stages
  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld       <= {vld[NVLD-2:0], in_valid};
      out_valid <= vld[NVLD-1];
    end
  end

  // first products
  always_ff @(posedge clk) begin
    if (en) begin
      xx <= eval_point * eval_point;
      xb <= eval_point * linear_coef;
      bb <= linear_coef * linear_coef;
      ac <= lead_coef * const_coef;
    end
  end

  // polynomial sum and discriminant, both wrapping in 64 bits
  assign xxa         = xx * lead_coef;
  assign poly_next   = W'(xxa) + (W'(xb) <<< FRAC_BITS)
                       + (c64 <<< (2 * FRAC_BITS));
  assign disc_next   = W'(bb) - (W'(ac) <<< 2);
  assign poly_full   = poly_next;
  assign poly_scaled = (poly_full >>> SH_R) <<< SH_L;

  always_ff @(posedge clk) begin
    if (en) begin
      poly_s1 <= poly_scaled[qer_pkg::POLY_W-1:0];
      disc    <= disc_next;
      if (lead_coef == '0) begin
        kind_s1 <= qer_pkg::KIND_LINEAR;
      end else if (disc_next[W-1]) begin
        kind_s1 <= qer_pkg::KIND_NONE;
      end else if (disc_next == '0) begin
        kind_s1 <= qer_pkg::KIND_DOUBLE;
      end else begin
        kind_s1 <= qer_pkg::KIND_TWO;
      end
    end
  end

  assign sq_in.rem = W'(disc) << (2 * qer_pkg::ROOT_EXTRA);
  assign sq_in.res = '0;

  for (genvar k = 0; k < NS; k++) begin : g_sqrt
    if (k == 0) begin : g_first
      qer_sqrt_cell #(.STEP(k)) u_cell (.clk(clk), .en(en), .din(sq_in), .dout(sq[k]));
    end else begin : g_rest
      qer_sqrt_cell #(.STEP(k)) u_cell (.clk(clk), .en(en), .din(sq[k-1]), .dout(sq[k]));
    end
  end

  // sideband: polynomial value and kind follow the root chain
  always_ff @(posedge clk) begin
    if (en) begin
      side[0] <= '{poly: poly_s1, kind: kind_s1};
      for (int i = 1; i < NSIDE; i++) begin
        side[i] <= side[i-1];
      end
    end
  end

  // set-up of the two divisions: signed numerators, magnitudes, overflow
  assign np  = base + sq[NS-1].res;
  assign nm  = base - sq[NS-1].res;
  assign nnp = np[W-1];
  assign nnm = nm[W-1];
  assign mnp = nnp ? (W'(0) - np) : np;
  assign mnm = nnm ? (W'(0) - nm) : nm;

  always_ff @(posedge clk) begin
    if (en) begin
      dv_in.plus.rem  <= mnp;
      dv_in.plus.quo  <= '0;
      dv_in.minus.rem <= mnm;
      dv_in.minus.quo <= '0;
      flg[0].neg_p <= nnp ^ lead_coef[COEF_WIDTH-1];
      flg[0].neg_m <= nnm ^ lead_coef[COEF_WIDTH-1];
      flg[0].big_p <= {32'd0, mnp} >= {md, 32'd0};
      flg[0].big_m <= {32'd0, mnm} >= {md, 32'd0};
      for (int i = 1; i <= ND; i++) begin
        flg[i] <= flg[i-1];
      end
    end
  end

  for (genvar j = 0; j < ND; j++) begin : g_div
    if (j == 0) begin : g_first
      qer_div_cell #(.SHIFT(ND - 1 - j)) u_cell (
        .clk(clk), .en(en), .divisor(md), .din(dv_in), .dout(dv[j]));
    end else begin : g_rest
      qer_div_cell #(.SHIFT(ND - 1 - j)) u_cell (
        .clk(clk), .en(en), .divisor(md), .din(dv[j-1]), .dout(dv[j]));
    end
  end

  // sign and clamp of a quotient
  function automatic logic [qer_pkg::ROOT_W:0] clamp_root(
    input logic [qer_pkg::ROOT_W-1:0] q,
    input logic                       neg,
    input logic                       big
  );
    logic [qer_pkg::ROOT_W:0] r;
    if (neg) begin
      if (big || q > {1'b1, {(qer_pkg::ROOT_W-1){1'b0}}}) begin
        r = {1'b1, 1'b1, {(qer_pkg::ROOT_W-1){1'b0}}};
      end else begin
        r = {1'b0, -q};
      end
    end else begin
      if (big || q[qer_pkg::ROOT_W-1]) begin
        r = {1'b1, 1'b0, {(qer_pkg::ROOT_W-1){1'b1}}};
      end else begin
        r = {1'b0, q};
      end
    end
    return r;
  endfunction

  logic [qer_pkg::ROOT_W:0] cp, cm;
  logic                     has_roots;

  assign cp = clamp_root(dv[ND-1].plus.quo,  flg[ND].neg_p, flg[ND].big_p);
  assign cm = clamp_root(dv[ND-1].minus.quo, flg[ND].neg_m, flg[ND].big_m);
  assign has_roots = (side[NSIDE-1].kind == qer_pkg::KIND_DOUBLE)
                  || (side[NSIDE-1].kind == qer_pkg::KIND_TWO);

  always_ff @(posedge clk) begin
    if (en) begin
      poly_value <= side[NSIDE-1].poly;
      root_kind  <= side[NSIDE-1].kind;
      if (has_roots) begin
        root_plus      <= cp[qer_pkg::ROOT_W-1:0];
        root_minus     <= cm[qer_pkg::ROOT_W-1:0];
        root_saturated <= cp[qer_pkg::ROOT_W] | cm[qer_pkg::ROOT_W];
      end else begin
        root_plus      <= '0;
        root_minus     <= '0;
        root_saturated <= 1'b0;
      end
    end
  end

endmodule
